/* src/arit_pkg.sv */
// shared constants, codes and types for the aged reply id table
// used by arit_match, the top level and the checker; depends on nothing

package arit_pkg;

    localparam int BANKS   = 2;
    localparam int ENTRIES = 16;
    localparam int SLOTS   = BANKS * ENTRIES;

    localparam int BANK_W   = $clog2(BANKS);
    localparam int ENT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int ID_W     = 32;
    localparam int TIME_W   = 32;
    localparam int AGE_W    = 16;
    localparam int STATUS_W = 3;
    localparam int RAM_W    = ID_W + TIME_W;

    localparam logic [AGE_W-1:0] AGE_RESET = 16'd60;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic              clear;
        logic              vld;
        logic              in_cur;
        logic              slot_vld;
        logic [BANK_W-1:0] bank;
        logic [ENT_W-1:0]  ent;
        logic [SLOT_W-1:0] idx;
    } cmp_t;

    typedef struct packed {
        logic              found;
        logic [BANK_W-1:0] found_bank;
        logic [ENT_W-1:0]  found_ent;
        logic              free;
        logic [ENT_W-1:0]  free_ent;
        logic [SLOT_W-1:0] free_idx;
        logic              recent;
    } match_t;

endpackage

/* src/arit_ram.sv */
// generic single-clock ram, one write port and one registered read port
// no dependencies

module arit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/arit_match.sv */
// compare stage of the table scan: id match, first free slot, recent entry
// depends on arit_pkg

module arit_match (
    input  logic                            clk,
    input  logic                            rst_n,
    input  arit_pkg::cmp_t                  cmp,
    input  logic [arit_pkg::RAM_W-1:0]      rdata,
    input  logic [arit_pkg::ID_W-1:0]       id,
    input  logic [arit_pkg::TIME_W-1:0]     now,
    input  logic [arit_pkg::AGE_W-1:0]      age_limit,
    output arit_pkg::match_t                match
);

    arit_pkg::match_t              match_reg;
    arit_pkg::match_t              match_next;
    logic [arit_pkg::ID_W-1:0]     slot_id;
    logic [arit_pkg::TIME_W-1:0]   slot_stamp;
    logic [arit_pkg::TIME_W-1:0]   age;

    assign slot_id    = rdata[arit_pkg::RAM_W-1:arit_pkg::TIME_W];
    assign slot_stamp = rdata[arit_pkg::TIME_W-1:0];
    assign age        = now - slot_stamp;

    always_comb
    begin
        match_next = match_reg;
        if (cmp.clear)
        begin
            match_next = '0;
        end
        else if (cmp.vld)
        begin
            if (cmp.slot_vld && slot_id == id && !match_reg.found)
            begin
                match_next.found      = 1'b1;
                match_next.found_bank = cmp.bank;
                match_next.found_ent  = cmp.ent;
            end
            if (cmp.in_cur && !cmp.slot_vld && !match_reg.free)
            begin
                match_next.free     = 1'b1;
                match_next.free_ent = cmp.ent;
                match_next.free_idx = cmp.idx;
            end
            if (cmp.in_cur && age < {{(arit_pkg::TIME_W-arit_pkg::AGE_W){1'b0}}, age_limit})
            begin
                match_next.recent = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

/* src/aged_reply_id_table.sv */
// top level of the aged reply id table: sequencer, valid bits, bank pointer
// depends on arit_pkg, arit_ram and arit_match

// usage:
// a transaction is accepted at a rising edge with start high and busy low;
// cmd, reply_id and now_seconds are sampled at that edge. cmd 0 inserts the
// id, cmd 1 takes it. busy stays high while the transaction is worked on.
// the block scans every slot of every bank through the slot memory, one
// slot per cycle, and then passes a drain and a finish state. the result
// (status, bank_rotated) is shown for one cycle with done high; busy is
// already low in that cycle, so the next transaction may be accepted
// then. the receiver cannot stall. age_limit is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while idle, the
// block itself does not enforce this.
// reset clears the slot valid bits, the current bank pointer and the
// sequencer and loads age_limit with 60; slot memory contents are not
// cleared and no clearing pass runs.

module aged_reply_id_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [arit_pkg::ID_W-1:0]         reply_id,
    input  logic [arit_pkg::TIME_W-1:0]       now_seconds,
    input  logic                              cfg_wr_en,
    input  logic [arit_pkg::AGE_W-1:0]        cfg_wr_data,
    output logic                              done,
    output logic [arit_pkg::STATUS_W-1:0]     status,
    output logic                              bank_rotated
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [arit_pkg::SLOT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [arit_pkg::BANK_W-1:0]    rd_bank_reg, rd_bank_next;
    logic [arit_pkg::ENT_W-1:0]     rd_ent_reg, rd_ent_next;
    logic [arit_pkg::BANK_W-1:0]    cur_bank_reg, cur_bank_next;
    logic [arit_pkg::SLOT_W-1:0]    cur_base_reg, cur_base_next;
    logic [arit_pkg::ENTRIES-1:0]   valid_reg [arit_pkg::BANKS];
    logic [arit_pkg::ENTRIES-1:0]   valid_next [arit_pkg::BANKS];
    logic                           cmd_reg, cmd_next;
    logic [arit_pkg::ID_W-1:0]      id_reg, id_next;
    logic [arit_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [arit_pkg::AGE_W-1:0]     age_limit_reg, age_limit_next;
    arit_pkg::cmp_t                 cmp_reg, cmp_next;
    logic                           done_reg, done_next;
    logic [arit_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                           rot_reg, rot_next;

    logic                           accept;
    logic                           ram_we;
    logic [arit_pkg::SLOT_W-1:0]    ram_waddr;
    logic [arit_pkg::RAM_W-1:0]     ram_rdata;
    logic [arit_pkg::BANK_W-1:0]    next_bank;
    logic [arit_pkg::SLOT_W-1:0]    next_base;
    arit_pkg::match_t               match;

    assign accept = start && (state_reg == S_IDLE);

    assign next_bank = (cur_bank_reg == arit_pkg::BANK_W'(arit_pkg::BANKS - 1))
                       ? '0 : cur_bank_reg + 1'b1;
    assign next_base = (cur_bank_reg == arit_pkg::BANK_W'(arit_pkg::BANKS - 1))
                       ? '0 : cur_base_reg + arit_pkg::SLOT_W'(arit_pkg::ENTRIES);

    arit_ram #(
        .WIDTH (arit_pkg::RAM_W),
        .DEPTH (arit_pkg::SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({id_reg, now_reg}),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    arit_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmp       (cmp_reg),
        .rdata     (ram_rdata),
        .id        (id_reg),
        .now       (now_reg),
        .age_limit (age_limit_reg),
        .match     (match)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        rd_bank_next   = rd_bank_reg;
        rd_ent_next    = rd_ent_reg;
        cur_bank_next  = cur_bank_reg;
        cur_base_next  = cur_base_reg;
        valid_next     = valid_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        age_limit_next = cfg_wr_en ? cfg_wr_data : age_limit_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        rot_next       = rot_reg;
        ram_we         = 1'b0;
        ram_waddr      = match.free_idx;

        cmp_next          = '0;
        cmp_next.clear    = accept;
        cmp_next.vld      = (state_reg == S_SCAN);
        cmp_next.in_cur   = (rd_bank_reg == cur_bank_reg);
        cmp_next.slot_vld = valid_reg[rd_bank_reg][rd_ent_reg];
        cmp_next.bank     = rd_bank_reg;
        cmp_next.ent      = rd_ent_reg;
        cmp_next.idx      = rd_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd;
                    id_next      = reply_id;
                    now_next     = now_seconds;
                    rd_idx_next  = '0;
                    rd_bank_next = '0;
                    rd_ent_next  = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                if (rd_ent_reg == arit_pkg::ENT_W'(arit_pkg::ENTRIES - 1))
                begin
                    rd_ent_next  = '0;
                    rd_bank_next = rd_bank_reg + 1'b1;
                end
                else
                begin
                    rd_ent_next = rd_ent_reg + 1'b1;
                end
                if (rd_idx_reg == arit_pkg::SLOT_W'(arit_pkg::SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                rot_next   = 1'b0;
                if (cmd_reg == arit_pkg::CMD_INSERT)
                begin
                    priority if (match.found)
                    begin
                        status_next = arit_pkg::ST_DUPLICATE;
                    end
                    else if (match.free)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = match.free_idx;
                        valid_next[cur_bank_reg][match.free_ent] = 1'b1;
                        status_next = arit_pkg::ST_INSERTED;
                    end
                    else if (match.recent)
                    begin
                        status_next = arit_pkg::ST_BUSY;
                    end
                    else
                    begin
                        ram_we                   = 1'b1;
                        ram_waddr                = next_base;
                        valid_next[next_bank]    = '0;
                        valid_next[next_bank][0] = 1'b1;
                        cur_bank_next            = next_bank;
                        cur_base_next            = next_base;
                        rot_next                 = 1'b1;
                        status_next              = arit_pkg::ST_INSERTED;
                    end
                end
                else
                begin
                    if (match.found)
                    begin
                        valid_next[match.found_bank][match.found_ent] = 1'b0;
                        status_next = arit_pkg::ST_TAKEN;
                    end
                    else
                    begin
                        status_next = arit_pkg::ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_bank_reg  <= '0;
            cur_base_reg  <= '0;
            age_limit_reg <= arit_pkg::AGE_RESET;
            cmp_reg       <= '0;
            done_reg      <= 1'b0;
            for (int b = 0; b < arit_pkg::BANKS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_bank_reg  <= cur_bank_next;
            cur_base_reg  <= cur_base_next;
            age_limit_reg <= age_limit_next;
            cmp_reg       <= cmp_next;
            done_reg      <= done_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        rd_bank_reg <= rd_bank_next;
        rd_ent_reg  <= rd_ent_next;
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        now_reg     <= now_next;
        status_reg  <= status_next;
        rot_reg     <= rot_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign bank_rotated = rot_reg;

endmodule

/* src/arit_checker.sv */
// port-level checks for the aged reply id table, attached by bind
// depends on arit_pkg and aged_reply_id_table

module arit_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [arit_pkg::STATUS_W-1:0]     status,
    input logic                              bank_rotated
);

    // a result never shows while a transaction is still being worked on
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // an accepted transaction holds busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // no result can follow an accept in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> !done)
        else $error("result too early after accept");

    // status stays within its defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == arit_pkg::ST_INSERTED || status == arit_pkg::ST_DUPLICATE ||
                  status == arit_pkg::ST_BUSY || status == arit_pkg::ST_TAKEN ||
                  status == arit_pkg::ST_NOT_FOUND))
        else $error("undefined status code");

    // a bank rotation only comes with a successful insert
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && bank_rotated) |-> (status == arit_pkg::ST_INSERTED))
        else $error("rotation without insert");

endmodule

bind aged_reply_id_table arit_checker u_arit_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .bank_rotated (bank_rotated)
);
